### sv/uart_baud_divisor_search_macros.svh
// Assertion macros used by the checker file.
`ifndef UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_MACROS_SVH

// Property checked outside reset.
`define UBDS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Property checked on every edge, reset included.
`define UBDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

### sv/ubds_pkg.sv
package ubds_pkg;

    // widths of the shared arithmetic
    localparam int DIV_W      = 40;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    // search range and constants
    localparam logic [7:0]  DIVIDER_FIRST = 8'd4;
    localparam logic [7:0]  DIVIDER_LAST  = 8'd254;
    localparam logic [7:0]  PERCENT       = 8'd100;

    // register reset values
    localparam logic [31:0] CLOCK_HZ_RESET  = 32'd50000000;
    localparam logic        PRESCALE_RESET  = 1'b0;
    localparam logic [6:0]  MAX_ERR_RESET   = 7'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_CLOCK_HZ  = 2'd0;
    localparam logic [1:0] CFG_PRESCALE  = 2'd1;
    localparam logic [1:0] CFG_MAX_ERR   = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_ERROR = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_CD,
        ST_GO_CD,
        ST_WAIT_CD,
        ST_MUL_RATE,
        ST_GO_RATE,
        ST_WAIT_RATE,
        ST_NEXT,
        ST_FINAL,
        ST_MUL_PCT,
        ST_GO_PCT,
        ST_WAIT_PCT,
        ST_DONE
    } state_t;

endpackage

### sv/uart_baud_divisor_search.sv
// UART baud divisor search.
// Input channel (s_*): one request carries a baud rate in s_tdata[31:0].
// Result channel (m_*): one result per request with status, clock divisor
// and baud divider. Dividers 4..254 are tried in rising order; the first
// with the smallest rate error wins, then the percent error is checked.
// Config port: cfg_we writes cfg_wdata into register cfg_addr (0 clock Hz,
// 1 prescale-by-8, 2 max error percent); the user writes only while idle,
// which the block itself does not enforce.
// A zero or too-fast rate goes from idle through ST_CHECK to ST_DONE. A
// search tries each candidate divider: a multiply (ST_MUL_CD), a start and a
// wait on the shared divider for the clock divisor, then, unless that is
// zero, a multiply, a start and a wait for the rate, then a step (ST_NEXT);
// then, if a divider was found, a multiply, a start and a wait for the
// percent check. The 40-bit divider sets each wait; one request is in
// flight, and s_tready is high only when idle.
// A finished result sits in an output register, so a new request is taken
// while the result waits; a stalled receiver holds m_tvalid/m_tdata and,
// once the next search is done, stalls the sequencer until taken.
// Reset (aresetn low, synchronous) empties the output register, returns
// the sequencer to idle and restores the register defaults.
module uart_baud_divisor_search (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] baud_rate
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [1:0] status, [33:2] clock_divisor,
                                   // [41:34] baud_divider, [47:42] zero
);

    // configuration registers
    logic [31:0] clk_hz_reg;
    logic        prescale_reg;
    logic [6:0]  max_err_reg;

    // sequencer
    ubds_pkg::state_t state_reg, state_next;

    // search datapath
    logic [31:0] baud_reg, baud_next;
    logic [31:0] clk_reg, clk_next;      // prescaled clock used by the search
    logic [7:0]  d_reg, d_next;          // candidate baud divider
    logic [39:0] prod_reg, prod_next;    // shared multiplier output
    logic [31:0] cd_reg, cd_next;        // candidate clock divisor
    logic        found_reg, found_next;
    logic [31:0] best_err_reg, best_err_next;
    logic [31:0] best_cd_reg, best_cd_next;
    logic [7:0]  best_div_reg, best_div_next;

    // result being built
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_cd_reg, res_cd_next;
    logic [7:0]  res_div_reg, res_div_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;

    // shared multiplier operands
    logic [31:0] mul_a;
    logic [7:0]  mul_b;
    logic [39:0] mul_p;

    // shared divider
    logic        div_start;
    logic [39:0] div_dividend;
    logic [39:0] div_divisor;
    logic [39:0] div_quot;
    logic        div_done;

    logic        accept;
    logic        out_free;
    logic        too_fast;
    logic [7:0]  d_plus1;
    logic [31:0] rate;
    logic [31:0] err;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    // 2*baud > clock, one bit wider so nothing overflows
    assign too_fast = {baud_reg, 1'b0} > {1'b0, clk_hz_reg};
    assign d_plus1  = d_reg + 8'd1;
    assign rate     = div_quot[31:0];
    assign err      = (baud_reg > rate) ? (baud_reg - rate) : (rate - baud_reg);
    assign mul_p    = {8'd0, mul_a} * {32'd0, mul_b};

    ubds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg   <= ubds_pkg::CLOCK_HZ_RESET;
            prescale_reg <= ubds_pkg::PRESCALE_RESET;
            max_err_reg  <= ubds_pkg::MAX_ERR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ubds_pkg::CFG_CLOCK_HZ: clk_hz_reg   <= cfg_wdata;
                ubds_pkg::CFG_PRESCALE: prescale_reg <= cfg_wdata[0];
                ubds_pkg::CFG_MAX_ERR:  max_err_reg  <= cfg_wdata[6:0];
                default: ;  // unused index, ignored
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ubds_pkg::ST_IDLE:
                if (accept) state_next = ubds_pkg::ST_CHECK;
            ubds_pkg::ST_CHECK:
                if (baud_reg == 32'd0 || too_fast) state_next = ubds_pkg::ST_DONE;
                else state_next = ubds_pkg::ST_MUL_CD;
            ubds_pkg::ST_MUL_CD:  state_next = ubds_pkg::ST_GO_CD;
            ubds_pkg::ST_GO_CD:   state_next = ubds_pkg::ST_WAIT_CD;
            ubds_pkg::ST_WAIT_CD:
                if (div_done) begin
                    if (div_quot == 40'd0) state_next = ubds_pkg::ST_NEXT;
                    else state_next = ubds_pkg::ST_MUL_RATE;
                end
            ubds_pkg::ST_MUL_RATE: state_next = ubds_pkg::ST_GO_RATE;
            ubds_pkg::ST_GO_RATE:  state_next = ubds_pkg::ST_WAIT_RATE;
            ubds_pkg::ST_WAIT_RATE:
                if (div_done) state_next = ubds_pkg::ST_NEXT;
            ubds_pkg::ST_NEXT:
                if (d_reg == ubds_pkg::DIVIDER_LAST) state_next = ubds_pkg::ST_FINAL;
                else state_next = ubds_pkg::ST_MUL_CD;
            ubds_pkg::ST_FINAL:
                if (found_reg) state_next = ubds_pkg::ST_MUL_PCT;
                else state_next = ubds_pkg::ST_DONE;
            ubds_pkg::ST_MUL_PCT: state_next = ubds_pkg::ST_GO_PCT;
            ubds_pkg::ST_GO_PCT:  state_next = ubds_pkg::ST_WAIT_PCT;
            ubds_pkg::ST_WAIT_PCT:
                if (div_done) state_next = ubds_pkg::ST_DONE;
            ubds_pkg::ST_DONE:
                if (out_free) state_next = ubds_pkg::ST_IDLE;
            default: state_next = ubds_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        baud_next       = baud_reg;
        clk_next        = clk_reg;
        d_next          = d_reg;
        prod_next       = prod_reg;
        cd_next         = cd_reg;
        found_next      = found_reg;
        best_err_next   = best_err_reg;
        best_cd_next    = best_cd_reg;
        best_div_next   = best_div_reg;
        res_status_next = res_status_reg;
        res_cd_next     = res_cd_reg;
        res_div_next    = res_div_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        s_tready        = 1'b0;
        mul_a           = baud_reg;
        mul_b           = d_plus1;
        div_start       = 1'b0;
        div_dividend    = {8'd0, clk_reg};
        div_divisor     = prod_reg;

        unique case (state_reg)
            ubds_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) baud_next = s_tdata;
            end
            ubds_pkg::ST_CHECK: begin
                res_status_next = ubds_pkg::STATUS_RANGE;
                res_cd_next     = 32'd0;
                res_div_next    = 8'd0;
                // prescale does not apply to the too-fast check
                clk_next   = prescale_reg ? {3'd0, clk_hz_reg[31:3]} : clk_hz_reg;
                d_next     = ubds_pkg::DIVIDER_FIRST;
                found_next = 1'b0;
            end
            ubds_pkg::ST_MUL_CD: begin
                // baud * (d + 1)
                prod_next = mul_p;
            end
            ubds_pkg::ST_GO_CD: begin
                div_start = 1'b1;
            end
            ubds_pkg::ST_WAIT_CD: begin
                if (div_done) cd_next = div_quot[31:0];
            end
            ubds_pkg::ST_MUL_RATE: begin
                // cd * (d + 1)
                mul_a     = cd_reg;
                prod_next = mul_p;
            end
            ubds_pkg::ST_GO_RATE: begin
                div_start = 1'b1;
            end
            ubds_pkg::ST_WAIT_RATE: begin
                // first divider with the smallest error is kept
                if (div_done && (!found_reg || err < best_err_reg)) begin
                    found_next    = 1'b1;
                    best_err_next = err;
                    best_cd_next  = cd_reg;
                    best_div_next = d_reg;
                end
            end
            ubds_pkg::ST_NEXT: begin
                d_next = d_plus1;
            end
            ubds_pkg::ST_FINAL: begin
                res_status_next = ubds_pkg::STATUS_ERROR;
                res_cd_next     = found_reg ? best_cd_reg : 32'd0;
                res_div_next    = found_reg ? best_div_reg : 8'd0;
            end
            ubds_pkg::ST_MUL_PCT: begin
                // best_err * 100
                mul_a     = best_err_reg;
                mul_b     = ubds_pkg::PERCENT;
                prod_next = mul_p;
            end
            ubds_pkg::ST_GO_PCT: begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = {8'd0, baud_reg};
            end
            ubds_pkg::ST_WAIT_PCT: begin
                if (div_done) begin
                    res_status_next = (div_quot > {33'd0, max_err_reg})
                                      ? ubds_pkg::STATUS_ERROR : ubds_pkg::STATUS_OK;
                end
            end
            ubds_pkg::ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'd0, res_div_reg, res_cd_reg, res_status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ubds_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
        end
        baud_reg       <= baud_next;
        clk_reg        <= clk_next;
        d_reg          <= d_next;
        prod_reg       <= prod_next;
        cd_reg         <= cd_next;
        best_err_reg   <= best_err_next;
        best_cd_reg    <= best_cd_next;
        best_div_reg   <= best_div_next;
        res_status_reg <= res_status_next;
        res_cd_reg     <= res_cd_next;
        res_div_reg    <= res_div_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/ubds_div.sv
// Restoring divider, one quotient bit per cycle.
module ubds_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [ubds_pkg::DIV_W-1:0]   dividend,
    input  logic [ubds_pkg::DIV_W-1:0]   divisor,
    output logic [ubds_pkg::DIV_W-1:0]   quotient,
    output logic                         done
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [ubds_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ubds_pkg::DIV_W-1:0]        rem_reg, rem_next;
    logic [ubds_pkg::DIV_W-1:0]        quo_reg, quo_next;
    logic [ubds_pkg::DIV_W-1:0]        dsr_reg, dsr_next;
    logic [ubds_pkg::DIV_W:0]          trial;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[ubds_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? ubds_pkg::DIV_W'(trial - {1'b0, dsr_reg})
                            : trial[ubds_pkg::DIV_W-1:0];
            quo_next = {quo_reg[ubds_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ubds_pkg::DIV_LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### sv/ubds_checker.sv
`include "uart_baud_divisor_search_macros.svh"

module ubds_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    `UBDS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `UBDS_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    `UBDS_ASSERT(a_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request taken while searching")

    `UBDS_ASSERT(a_range_zero, aclk, aresetn, m_tvalid && m_tdata[1:0] == ubds_pkg::STATUS_RANGE |-> m_tdata[41:2] == 40'd0, "range status with nonzero divisors")

    `UBDS_ASSERT(a_ok_pair, aclk, aresetn, m_tvalid && m_tdata[1:0] == ubds_pkg::STATUS_OK |-> m_tdata[41:34] >= ubds_pkg::DIVIDER_FIRST && m_tdata[41:34] <= ubds_pkg::DIVIDER_LAST && m_tdata[33:2] != 32'd0, "ok status with bad pair")

endmodule

bind uart_baud_divisor_search ubds_checker u_ubds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
